@@ src/mcsw_pkg.sv @@
// ----------------------------------------------------------------------------
// mcsw_pkg
// Shared types and constants for the multi-channel sensor watchdog.
// ----------------------------------------------------------------------------
package mcsw_pkg;

    localparam int MODE_W       = 2;
    localparam int CHANNEL_W    = 2;
    localparam int TIMEOUT_IN_W = 24;
    localparam int TRIGGER_W    = 16;
    localparam int MASK_W       = 4;

    localparam logic [TRIGGER_W-1:0] COUNT_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_PET  = 2'd1,
        MODE_ADD  = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

endpackage

@@ src/mcsw_req_if.sv @@
// ----------------------------------------------------------------------------
// mcsw_req_if
// Request channel: valid/ready handshake carrying one watchdog command.
// ----------------------------------------------------------------------------
interface mcsw_req_if
    import mcsw_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic [CHANNEL_W-1:0]    channel;
    logic [TIMEOUT_IN_W-1:0] timeout_ticks;
    logic [TRIGGER_W-1:0]    trigger_limit;

    modport source (output valid, output mode, output channel, output timeout_ticks,
                    output trigger_limit, input ready);
    modport sink   (input valid, input mode, input channel, input timeout_ticks,
                    input trigger_limit, output ready);
endinterface

@@ src/mcsw_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mcsw_rsp_if
// Response channel: valid/ready handshake carrying per-channel status masks.
// ----------------------------------------------------------------------------
interface mcsw_rsp_if
    import mcsw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] expired_mask;
    logic [MASK_W-1:0] halted_mask;
    logic [MASK_W-1:0] running_mask;
    logic              pet_hit;

    modport source (output valid, output expired_mask, output halted_mask,
                    output running_mask, output pet_hit, input ready);
    modport sink   (input valid, input expired_mask, input halted_mask,
                    input running_mask, input pet_hit, output ready);
endinterface

@@ src/multi_channel_sensor_watchdog_top.sv @@
// ----------------------------------------------------------------------------
// multi_channel_sensor_watchdog_top
// Bank of watchdog channels driven by tick / pet / add commands.
//
//   channel | dir | payload                                          | handshake
//   req     | in  | mode, channel, timeout_ticks, trigger_limit      | valid/ready
//   rsp     | out | expired_mask, halted_mask, running_mask, pet_hit | valid/ready
//
// One transaction per cycle unless a stalled response holds req.ready low; each
// accepted request yields one response, registered in the next cycle. All
// channels update in parallel, loaded in the same cycle as the response register.
// rst_n clears all channel state and the response valid flag, not the status masks.
// A stalled response holds req.ready low until it is taken, or taken the same cycle.
// ----------------------------------------------------------------------------
module multi_channel_sensor_watchdog_top
    import mcsw_pkg::*;
#(
    parameter int NUM_CHANNELS  = 4,
    parameter int TIMEOUT_WIDTH = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    mcsw_req_if.sink     req,
    mcsw_rsp_if.source   rsp
);

    localparam int TW = TIMEOUT_WIDTH;
    localparam logic [TW-1:0] T_ONE = TW'(1);

    logic [TW-1:0]        remaining_reg    [NUM_CHANNELS];
    logic [TW-1:0]        remaining_next   [NUM_CHANNELS];
    logic [TW-1:0]        period_reg       [NUM_CHANNELS];
    logic [TW-1:0]        period_next      [NUM_CHANNELS];
    logic [TRIGGER_W-1:0] limit_reg        [NUM_CHANNELS];
    logic [TRIGGER_W-1:0] limit_next       [NUM_CHANNELS];
    logic [TRIGGER_W-1:0] count_reg        [NUM_CHANNELS];
    logic [TRIGGER_W-1:0] count_next       [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] running_reg, running_next;
    logic [NUM_CHANNELS-1:0] configured_reg, configured_next;
    logic [NUM_CHANNELS-1:0] expired_n, halted_n;
    logic                    hit_n;

    logic [MASK_W-1:0] expired_reg, expired_next;
    logic [MASK_W-1:0] halted_reg, halted_next;
    logic [MASK_W-1:0] running_mask_reg, running_mask_next;
    logic              pet_hit_reg;
    logic              rsp_valid_reg;

    logic          req_acc;
    logic [TW-1:0] tmo;
    logic [TW-1:0] new_period;
    mode_t         mode;

    assign mode      = mode_t'(req.mode);
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;

    generate
        if (TW > TIMEOUT_IN_W) begin : g_tmo_ext
            assign tmo = {{(TW-TIMEOUT_IN_W){1'b0}}, req.timeout_ticks};
        end
        else if (TW == TIMEOUT_IN_W) begin : g_tmo_eq
            assign tmo = req.timeout_ticks;
        end
        else begin : g_tmo_trunc
            assign tmo = req.timeout_ticks[TW-1:0];
        end
    endgenerate

    assign new_period = (tmo == '0) ? T_ONE : tmo;

    always_comb
    begin
        hit_n = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            remaining_next[i]  = remaining_reg[i];
            period_next[i]     = period_reg[i];
            limit_next[i]      = limit_reg[i];
            count_next[i]      = count_reg[i];
            running_next[i]    = running_reg[i];
            configured_next[i] = configured_reg[i];
            expired_n[i]       = 1'b0;
            halted_n[i]        = 1'b0;
            case (mode)
                MODE_TICK:
                begin
                    if (running_reg[i])
                    begin
                        if (remaining_reg[i] > T_ONE)
                        begin
                            remaining_next[i] = remaining_reg[i] - T_ONE;
                        end
                        else
                        begin
                            expired_n[i]      = 1'b1;
                            remaining_next[i] = period_reg[i];
                            if (limit_reg[i] != '0)
                            begin
                                if (count_reg[i] < limit_reg[i])
                                begin
                                    count_next[i] = count_reg[i] + 1'b1;
                                end
                                else
                                begin
                                    running_next[i] = 1'b0;
                                    halted_n[i]     = 1'b1;
                                end
                            end
                            else if (count_reg[i] != COUNT_MAX)
                            begin
                                count_next[i] = count_reg[i] + 1'b1;
                            end
                        end
                    end
                end
                MODE_PET:
                begin
                    if ((int'(req.channel) == i) && configured_reg[i])
                    begin
                        count_next[i]     = '0;
                        remaining_next[i] = period_reg[i];
                        running_next[i]   = 1'b1;
                        hit_n             = 1'b1;
                    end
                end
                MODE_ADD:
                begin
                    if (int'(req.channel) == i)
                    begin
                        configured_next[i] = 1'b1;
                        period_next[i]     = new_period;
                        remaining_next[i]  = new_period;
                        limit_next[i]      = req.trigger_limit;
                        count_next[i]      = '0;
                        running_next[i]    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    generate
        for (genvar b = 0; b < MASK_W; b++)
        begin : g_mask
            if (b < NUM_CHANNELS) begin : g_live
                assign expired_next[b]      = expired_n[b];
                assign halted_next[b]       = halted_n[b];
                assign running_mask_next[b] = running_next[b];
            end
            else begin : g_dead
                assign expired_next[b]      = 1'b0;
                assign halted_next[b]       = 1'b0;
                assign running_mask_next[b] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                remaining_reg[i] <= '0;
                period_reg[i]    <= '0;
                limit_reg[i]     <= '0;
                count_reg[i]     <= '0;
            end
            running_reg    <= '0;
            configured_reg <= '0;
        end
        else if (req_acc)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                remaining_reg[i] <= remaining_next[i];
                period_reg[i]    <= period_next[i];
                limit_reg[i]     <= limit_next[i];
                count_reg[i]     <= count_next[i];
            end
            running_reg    <= running_next;
            configured_reg <= configured_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req_acc)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            expired_reg      <= expired_next;
            halted_reg       <= halted_next;
            running_mask_reg <= running_mask_next;
            pet_hit_reg      <= hit_n;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.expired_mask = expired_reg;
    assign rsp.halted_mask  = halted_reg;
    assign rsp.running_mask = running_mask_reg;
    assign rsp.pet_hit      = pet_hit_reg;

    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> rsp_valid_reg)
        else $error("response missing after accepted request");

    a_halt_is_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((halted_reg & ~expired_reg) == '0))
        else $error("halted channel without expiry");

    a_halt_stops: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((halted_reg & running_mask_reg) == '0))
        else $error("halted channel still running");

    a_pet_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && pet_hit_reg) |-> (expired_reg == '0 && halted_reg == '0))
        else $error("pet response carries tick status");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-channel sensor watchdog. A short directed
// table covers reset state, unset pets, no-ops, zero and full-scale periods,
// limit halts and re-adds. A few hundred random commands follow, mostly ticks
// with short periods and small limits so that expiries and halts recur. Both
// sides idle in random bursts, and one long response stall backs up the
// request side. Every response is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
    import mcsw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCH         = 4;
    localparam int NDIR        = 23;
    localparam int N_RAND      = 480;
    localparam int TAIL        = 80;
    localparam int HOLD_CYCLES = 48;
    localparam int STALL_LIMIT = 1000;

    typedef struct packed {
        mode_t                   mode;
        logic [CHANNEL_W-1:0]    chan;
        logic [TIMEOUT_IN_W-1:0] tmo;
        logic [TRIGGER_W-1:0]    lim;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] expired;
        logic [MASK_W-1:0] halted;
        logic [MASK_W-1:0] running;
        logic              pet;
    } status_t;

    typedef struct packed {
        cmd_t    cmd;
        logic    typed;
        status_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    mcsw_req_if req_bus ();
    mcsw_rsp_if rsp_bus ();

    multi_channel_sensor_watchdog_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // channel bank as seen by the predictor
    logic [TIMEOUT_IN_W-1:0] ch_left   [NCH];
    logic [TIMEOUT_IN_W-1:0] ch_period [NCH];
    logic [TRIGGER_W-1:0]    ch_limit  [NCH];
    logic [TRIGGER_W-1:0]    ch_fires  [NCH];
    logic [NCH-1:0]          ch_run;
    logic [NCH-1:0]          ch_armed;

    status_t pending_status [$];

    bit          quiet_tail;
    bit          hold_done;
    int unsigned errors;
    int unsigned rsp_seen;
    int unsigned stall_cycles;
    int unsigned n_tick, n_pet, n_add, n_nop;
    int unsigned n_expiry, n_halt, n_hit;

    dir_row_t dir_table [NDIR] = '{
        '{'{MODE_TICK, 2'd0, 24'd0,        16'd0},      1'b1, '{4'h0, 4'h0, 4'h0, 1'b0}},
        '{'{MODE_PET,  2'd2, 24'd5,        16'd3},      1'b1, '{4'h0, 4'h0, 4'h0, 1'b0}},
        '{'{MODE_NOP,  2'd3, 24'hFFFFFF,   16'hFFFF},   1'b1, '{4'h0, 4'h0, 4'h0, 1'b0}},
        '{'{MODE_ADD,  2'd0, 24'd0,        16'd0},      1'b1, '{4'h0, 4'h0, 4'h1, 1'b0}},
        '{'{MODE_TICK, 2'd0, 24'd0,        16'd0},      1'b1, '{4'h1, 4'h0, 4'h1, 1'b0}},
        '{'{MODE_ADD,  2'd1, 24'd2,        16'd1},      1'b1, '{4'h0, 4'h0, 4'h3, 1'b0}},
        '{'{MODE_TICK, 2'd3, 24'hFFFFFF,   16'hFFFF},   1'b0, '0},
        '{'{MODE_TICK, 2'd0, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_TICK, 2'd1, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_TICK, 2'd2, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_PET,  2'd1, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_ADD,  2'd2, 24'hFFFFFF,   16'hFFFF},   1'b0, '0},
        '{'{MODE_ADD,  2'd3, 24'd1,        16'd0},      1'b0, '0},
        '{'{MODE_TICK, 2'd0, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_PET,  2'd3, 24'hFFFFFF,   16'hFFFF},   1'b0, '0},
        '{'{MODE_ADD,  2'd0, 24'd3,        16'd2},      1'b0, '0},
        '{'{MODE_NOP,  2'd0, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_TICK, 2'd0, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_TICK, 2'd0, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_TICK, 2'd0, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_PET,  2'd0, 24'd0,        16'd0},      1'b0, '0},
        '{'{MODE_ADD,  2'd1, 24'hAAAAAA,   16'h5555},   1'b0, '0},
        '{'{MODE_TICK, 2'd0, 24'h555555,   16'hAAAA},   1'b0, '0}
    };

    function automatic status_t advance_bank(input cmd_t c);
        status_t s;
        s = '0;
        case (c.mode)
            MODE_TICK:
            begin
                for (int i = 0; i < NCH; i++)
                begin
                    if (ch_run[i])
                    begin
                        if (ch_left[i] > 1)
                            ch_left[i] = ch_left[i] - 1'b1;
                        else
                        begin
                            s.expired[i] = 1'b1;
                            ch_left[i]   = ch_period[i];
                            if (ch_limit[i] != '0)
                            begin
                                if (ch_fires[i] < ch_limit[i])
                                    ch_fires[i] = ch_fires[i] + 1'b1;
                                else
                                begin
                                    ch_run[i]   = 1'b0;
                                    s.halted[i] = 1'b1;
                                end
                            end
                            else if (ch_fires[i] != COUNT_MAX)
                                ch_fires[i] = ch_fires[i] + 1'b1;
                        end
                    end
                end
            end
            MODE_PET:
            begin
                if (ch_armed[c.chan])
                begin
                    ch_fires[c.chan] = '0;
                    ch_left[c.chan]  = ch_period[c.chan];
                    ch_run[c.chan]   = 1'b1;
                    s.pet            = 1'b1;
                end
            end
            MODE_ADD:
            begin
                ch_armed[c.chan]  = 1'b1;
                ch_period[c.chan] = (c.tmo == '0) ? 24'd1 : c.tmo;
                ch_left[c.chan]   = ch_period[c.chan];
                ch_limit[c.chan]  = c.lim;
                ch_fires[c.chan]  = '0;
                ch_run[c.chan]    = 1'b1;
            end
            default: ;
        endcase
        s.running = ch_run;
        return s;
    endfunction

    // mostly ticks over short periods and small limits
    function automatic cmd_t rand_cmd();
        cmd_t        c;
        int unsigned r;
        r      = $urandom_range(0, 99);
        c.chan = CHANNEL_W'($urandom_range(0, NCH - 1));
        c.tmo  = TIMEOUT_IN_W'($urandom);
        c.lim  = TRIGGER_W'($urandom);
        if (r < 55)
            c.mode = MODE_TICK;
        else if (r < 70)
            c.mode = MODE_PET;
        else if (r < 90)
        begin
            c.mode = MODE_ADD;
            r = $urandom_range(0, 9);
            if (r == 0)
                c.tmo = '0;
            else if (r > 1)
                c.tmo = TIMEOUT_IN_W'($urandom_range(1, 6));
            if ($urandom_range(0, 7) != 0)
                c.lim = TRIGGER_W'($urandom_range(0, 3));
        end
        else
            c.mode = MODE_NOP;
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c, input logic typed, input status_t want);
        status_t pred;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        req_bus.mode          = c.mode;
        req_bus.channel       = c.chan;
        req_bus.timeout_ticks = c.tmo;
        req_bus.trigger_limit = c.lim;
        req_bus.valid         = 1'b1;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pred = advance_bank(c);
        pending_status.push_back(typed ? want : pred);
        case (c.mode)
            MODE_TICK: n_tick++;
            MODE_PET:  n_pet++;
            MODE_ADD:  n_add++;
            default:   n_nop++;
        endcase
        n_expiry += $countones(pred.expired);
        n_halt   += $countones(pred.halted);
        n_hit    += pred.pet;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        errors++;
        if (errors <= 30)
            $display("MISMATCH rsp %0d %s: got %0h expected %0h", rsp_seen, what, got, want);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
    end

    always #10 clk = ~clk;

    initial
    begin
        cmd_t c;
        req_bus.valid         = 1'b0;
        req_bus.mode          = MODE_NOP;
        req_bus.channel       = '0;
        req_bus.timeout_ticks = '0;
        req_bus.trigger_limit = '0;
        ch_run                = '0;
        ch_armed              = '0;
        for (int i = 0; i < NCH; i++)
        begin
            ch_left[i]   = '0;
            ch_period[i] = '0;
            ch_limit[i]  = '0;
            ch_fires[i]  = '0;
        end
        @(posedge rst_n);
        @(negedge clk);
        for (int k = 0; k < NDIR; k++)
            send_cmd(dir_table[k].cmd, dir_table[k].typed, dir_table[k].want);
        for (int k = 0; k < N_RAND; k++)
        begin
            quiet_tail = (k >= N_RAND - TAIL);
            c = rand_cmd();
            send_cmd(c, 1'b0, '0);
        end
        req_bus.valid = 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (pending_status.size() != 0)
            report_mismatch("responses missing", pending_status.size(), 0);
        $display("Commands: %0d ticks, %0d pets, %0d adds, %0d no-ops; %0d responses checked",
                 n_tick, n_pet, n_add, n_nop, rsp_seen);
        $display("Events: %0d channel expiries, %0d limit halts, %0d pet hits",
                 n_expiry, n_halt, n_hit);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // response side: random back-pressure plus one long stall
    initial
    begin
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && rsp_seen >= 150)
            begin
                rsp_bus.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                rsp_bus.ready = 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(negedge clk);
            end
            else
                rsp_bus.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_rsp
        status_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            rsp_seen++;
            if (pending_status.size() == 0)
                report_mismatch("unexpected transaction", rsp_bus.running_mask, 0);
            else
            begin
                want = pending_status.pop_front();
                if (rsp_bus.expired_mask !== want.expired)
                    report_mismatch("expired_mask", rsp_bus.expired_mask, want.expired);
                if (rsp_bus.halted_mask !== want.halted)
                    report_mismatch("halted_mask", rsp_bus.halted_mask, want.halted);
                if (rsp_bus.running_mask !== want.running)
                    report_mismatch("running_mask", rsp_bus.running_mask, want.running);
                if (rsp_bus.pet_hit !== want.pet)
                    report_mismatch("pet_hit", rsp_bus.pet_hit, want.pet);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", stall_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
